>>> rtl/core/triggered_delay_timer_with_lockout_defines.svh
// Assertion macros shared by the checker of the delay timer block.
`ifndef TRIGGERED_DELAY_TIMER_WITH_LOCKOUT_DEFINES_SVH
`define TRIGGERED_DELAY_TIMER_WITH_LOCKOUT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define TDT_ASSERT_SAME(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("tdt assertion failed");

// Condition holds in the cycle after the trigger.
`define TDT_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("tdt assertion failed");

`endif

>>> rtl/core/tdt_pkg.sv
// Types and constants of the triggered delay timer with lockout.
`timescale 1ns / 1ps
package tdt_pkg;

  typedef enum logic [2:0] {
    PH_RESET    = 3'd0,
    PH_FIRST    = 3'd1,
    PH_LAST     = 3'd2,
    PH_LOCKOUT  = 3'd3,
    PH_COMPLETE = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_STOP = 2'd1,
    ERR_PIN  = 2'd2
  } err_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIN_PRESENT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_PIN  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MODE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_TRIG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MONO_STABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_US    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_US    = 3'd6;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 112;

  // Configuration as the datapath sees it; the timer values are kept as
  // thresholds with the margin already taken off.
  typedef struct packed {
    logic        pin_present;
    logic        invert_pin;
    logic        pulse_mode;
    logic        last_trigger_mode;
    logic        mono_stable_mode;
    logic        delay_nz;
    logic        block_nz;
    logic [31:0] delay_thr;
    logic [31:0] block_thr;
  } cfg_t;

  typedef struct packed {
    logic        clear_req;
    logic        read_en_value;
    logic        read_en_write;
    logic        stop_block_req;
    logic        stop_delay_req;
    logic        soft_level;
    logic        soft_write;
    logic        pin_level;
    logic [31:0] time_us;
  } item_t;

  typedef struct packed {
    logic [5:0]  pad;
    err_t        error_code;
    logic [31:0] end_time;
    logic [31:0] last_time;
    logic [31:0] first_time;
    logic        went_high;
    logic        went_low;
    logic        pin_state;
    phase_t      phase;
    logic        phase_changed;
    logic        active;
  } result_t;

endpackage

>>> rtl/core/tdt_cfg.sv
// Configuration registers and timer thresholds.
`timescale 1ns / 1ps
module tdt_cfg #(
  parameter int unsigned MARGIN_US = 500
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [tdt_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  output tdt_pkg::cfg_t                 cfg
);
  import tdt_pkg::*;

  localparam logic [31:0] MARGIN = 32'(MARGIN_US);

  localparam cfg_t CFG_RESET = '{
    pin_present:       1'b1,
    invert_pin:        1'b0,
    pulse_mode:        1'b0,
    last_trigger_mode: 1'b0,
    mono_stable_mode:  1'b0,
    delay_nz:          1'b0,
    block_nz:          1'b0,
    delay_thr:         32'd0,
    block_thr:         32'd0
  };

  logic [31:0] thr_next;

  // Threshold saturates at zero when the time is below the margin.
  assign thr_next = (wr_data > MARGIN) ? (wr_data - MARGIN) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_PIN_PRESENT: cfg.pin_present       <= wr_data[0];
        CFG_INVERT_PIN:  cfg.invert_pin        <= wr_data[0];
        CFG_PULSE_MODE:  cfg.pulse_mode        <= wr_data[0];
        CFG_LAST_TRIG:   cfg.last_trigger_mode <= wr_data[0];
        CFG_MONO_STABLE: cfg.mono_stable_mode  <= wr_data[0];
        CFG_DELAY_US: begin
          cfg.delay_nz  <= |wr_data;
          cfg.delay_thr <= thr_next;
        end
        CFG_BLOCK_US: begin
          cfg.block_nz  <= |wr_data;
          cfg.block_thr <= thr_next;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/tdt_core.sv
// Timer state and the per-tick phase logic.
`timescale 1ns / 1ps
module tdt_core #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  tdt_pkg::item_t   item,
  input  tdt_pkg::cfg_t    cfg,
  output tdt_pkg::result_t result
);
  import tdt_pkg::*;

  localparam int unsigned CW = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;

  typedef struct packed {
    logic                  active;
    logic                  lockout;
    logic                  read_en;
    logic                  saved_read_en;
    logic                  soft_in;
    logic                  held;
    logic                  prev;
    logic                  stop_delay;
    logic                  stop_block;
    phase_t                phase;
    logic [TIME_WIDTH-1:0] first_stamp;
    logic [TIME_WIDTH-1:0] last_stamp;
    logic [TIME_WIDTH-1:0] end_stamp;
    logic [TIME_WIDTH-1:0] block_stamp;
  } state_t;

  localparam state_t ST_RESET = '{
    active:        1'b0,
    lockout:       1'b0,
    read_en:       1'b1,
    saved_read_en: 1'b0,
    soft_in:       1'b1,
    held:          1'b1,
    prev:          1'b1,
    stop_delay:    1'b0,
    stop_block:    1'b0,
    phase:         PH_RESET,
    first_stamp:   '0,
    last_stamp:    '0,
    end_stamp:     '0,
    block_stamp:   '0
  };

  state_t                st, st_next;
  logic [TIME_WIDTH-1:0] now;
  logic                  cur, low, high, changed, do_end;
  err_t                  err;

  function automatic logic expired(input logic [TIME_WIDTH-1:0] stamp,
                                   input logic [TIME_WIDTH-1:0] t,
                                   input logic [31:0] thr);
    logic [TIME_WIDTH-1:0] el;
    el = t - stamp;
    return CW'(el) >= CW'(thr);
  endfunction

  assign now = TIME_WIDTH'(item.time_us);

  always_comb begin
    st_next = st;
    err     = ERR_NONE;
    cur     = 1'b0;
    low     = 1'b0;
    high    = 1'b0;
    changed = 1'b0;
    do_end  = 1'b0;
    if (item.clear_req) begin
      st_next.first_stamp = '0;
      st_next.last_stamp  = '0;
      st_next.end_stamp   = '0;
      st_next.block_stamp = '0;
      st_next.stop_delay  = 1'b0;
      st_next.stop_block  = 1'b0;
      st_next.held        = 1'b1;
      if (st.lockout) begin
        st_next.read_en = st.saved_read_en;
      end
      st_next.lockout = 1'b0;
      st_next.active  = 1'b0;
      st_next.soft_in = 1'b1;
      st_next.prev    = 1'b1;
      st_next.phase   = PH_RESET;
      changed         = 1'b1;
    end else begin
      if (item.soft_write) begin
        st_next.soft_in = item.soft_level;
      end
      if (item.read_en_write) begin
        if (item.read_en_value && !cfg.pin_present) begin
          err = ERR_PIN;
        end else if (st.lockout) begin
          st_next.saved_read_en = item.read_en_value;
        end else begin
          st_next.read_en = item.read_en_value;
        end
      end
      if (item.stop_delay_req) begin
        if (st.active && cfg.delay_nz) begin
          st_next.stop_delay = 1'b1;
        end else begin
          err = ERR_STOP;
        end
      end
      if (item.stop_block_req) begin
        if (st.active && cfg.block_nz) begin
          st_next.stop_block = 1'b1;
        end else begin
          err = ERR_STOP;
        end
      end

      if (st_next.read_en && cfg.pin_present) begin
        st_next.held = item.pin_level ^ cfg.invert_pin;
      end
      cur = st_next.held & st_next.soft_in;
      if (cfg.pulse_mode && !st_next.soft_in) begin
        st_next.soft_in = 1'b1;
      end
      low  = st.prev & ~cur;
      high = ~st.prev & cur;

      if (st.lockout) begin
        do_end = 1'b1;
      end else if (!cfg.delay_nz) begin
        if (low && !st.active) begin
          st_next.active      = 1'b1;
          st_next.first_stamp = now;
          st_next.last_stamp  = now;
          st_next.phase       = PH_FIRST;
          changed             = 1'b1;
        end
        do_end = high;
      end else begin
        if (low && !st.active) begin
          st_next.active      = 1'b1;
          st_next.first_stamp = now;
          st_next.last_stamp  = now;
          st_next.phase       = PH_FIRST;
          changed             = 1'b1;
        end
        if (st_next.active) begin
          if (cfg.last_trigger_mode && high) begin
            st_next.phase      = PH_LAST;
            st_next.last_stamp = now;
            changed            = 1'b1;
          end
          if (expired(cfg.last_trigger_mode ? st_next.last_stamp : st_next.first_stamp,
                      now, cfg.delay_thr) || st_next.stop_delay) begin
            st_next.stop_delay = 1'b0;
            do_end = cfg.mono_stable_mode | cur;
          end
        end
      end

      // End of the active phase: enter lockout if configured and leave it once its
      // time is up or a stop was requested; without lockout, complete directly.
      if (do_end) begin
        if (st_next.lockout || cfg.block_nz) begin
          if (!st_next.lockout) begin
            st_next.lockout       = 1'b1;
            st_next.saved_read_en = st_next.read_en;
            st_next.read_en       = 1'b0;
            st_next.block_stamp   = now;
            st_next.phase         = PH_LOCKOUT;
            changed               = 1'b1;
          end
          if (expired(st_next.block_stamp, now, cfg.block_thr) || st_next.stop_block) begin
            st_next.lockout    = 1'b0;
            st_next.read_en    = st_next.saved_read_en;
            st_next.stop_delay = 1'b0;
            st_next.stop_block = 1'b0;
            st_next.end_stamp  = now;
            st_next.active     = 1'b0;
            st_next.phase      = PH_COMPLETE;
            changed            = 1'b1;
          end
        end else begin
          st_next.stop_delay = 1'b0;
          st_next.stop_block = 1'b0;
          st_next.end_stamp  = now;
          st_next.active     = 1'b0;
          st_next.phase      = PH_COMPLETE;
          changed            = 1'b1;
        end
      end
      st_next.prev = cur;
    end
  end

  always_comb begin
    result               = '0;
    result.active        = st_next.active;
    result.phase_changed = changed;
    result.phase         = st_next.phase;
    result.pin_state     = st_next.held;
    result.went_low      = low;
    result.went_high     = high;
    result.first_time    = 32'(st_next.first_stamp);
    result.last_time     = 32'(st_next.last_stamp);
    result.end_time      = 32'(st_next.end_stamp);
    result.error_code    = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

>>> rtl/core/triggered_delay_timer_with_lockout.sv
// Top level of the triggered delay timer with lockout.
`timescale 1ns / 1ps
// Retriggerable monostable with lockout. Each input word is one tick and
// yields exactly one result word. A word passes an input register, then the
// phase logic, then the result register; the timer state is updated as the
// word moves into the result register. One word is taken every cycle while
// the sink takes results. While a result waits for the sink, the input
// register takes at most one more word and then holds the source off until
// the result is taken. Configuration writes are taken at any time and
// should be made while the block is idle; they take effect for the next
// tick.
module triggered_delay_timer_with_lockout #(
  parameter int unsigned MARGIN_US  = 500,
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // time_us[31:0], pin_level, soft_write, soft_level, stop_delay_req,
  // stop_block_req, read_en_write, read_en_value, clear_req
  input  logic [tdt_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // active, phase_changed, phase[2:0], pin_state, went_low, went_high,
  // first_time[31:0], last_time[31:0], end_time[31:0], error_code[1:0], zeros
  output logic [tdt_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);
  import tdt_pkg::*;

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance;
  result_t result;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;

  tdt_cfg #(
    .MARGIN_US (MARGIN_US)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tdt_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_item),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= item_t'(s_tdata);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= OUT_DATA_W'(result);
    end
  end

endmodule

>>> rtl/core/tdt_checker.sv
// Port-level checks of the delay timer block and their binding.
`timescale 1ns / 1ps
`include "triggered_delay_timer_with_lockout_defines.svh"
module tdt_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [tdt_pkg::OUT_DATA_W-1:0] m_tdata
);
  import tdt_pkg::*;

  logic [2:0] out_phase;
  logic [1:0] out_err;
  logic       out_active;
  logic       out_changed;
  logic       out_low;
  logic       out_high;
  logic       busy_phase;
  logic       clear_word;
  logic       quiet_word;
  logic       out_free;

  assign out_phase   = m_tdata[4:2];
  assign out_err     = m_tdata[105:104];
  assign out_active  = m_tdata[0];
  assign out_changed = m_tdata[1];
  assign out_low     = m_tdata[6];
  assign out_high    = m_tdata[7];
  assign busy_phase  = out_phase == PH_FIRST || out_phase == PH_LAST ||
                       out_phase == PH_LOCKOUT;
  // Only a clear changes the phase and leaves it in the reset phase.
  assign clear_word  = out_changed && out_phase == PH_RESET;
  assign quiet_word  = !out_low && !out_high && out_err == ERR_NONE && !out_active;
  assign out_free    = !m_tvalid || m_tready;

  // A stalled result word stays offered.
  `TDT_ASSERT_NEXT(a_hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)

  // An active result is always in the first, last or lockout phase.
  `TDT_ASSERT_SAME(a_active_phase, clk, rst, m_tvalid && out_active, busy_phase)

  // The combined level cannot fall and rise in the same tick.
  `TDT_ASSERT_SAME(a_one_edge, clk, rst, m_tvalid, !(out_low && out_high))

  // A clear word reports no edges and no error.
  `TDT_ASSERT_SAME(a_clear_quiet, clk, rst, m_tvalid && clear_word, quiet_word)

  // The input side is ready whenever the result side can move.
  `TDT_ASSERT_SAME(a_ready_when_free, clk, rst, out_free, s_tready)

endmodule

bind triggered_delay_timer_with_lockout tdt_checker u_tdt_checker (.*);
